// ===== hw/rtl/hsv_pkg.sv =====
// ----------------------------------------------------------------------------
// hsv_pkg
// Shared types, constants and rounding helper for the HSV to RGB pipeline.
// ----------------------------------------------------------------------------
package hsv_pkg;

	localparam int unsigned HUE_W  = 16;
	localparam int unsigned LVL_W  = 16;
	localparam int unsigned FRAC_W = 16;
	localparam int unsigned FAC_W  = 32;
	localparam int unsigned PROD_W = LVL_W + FAC_W;
	localparam int unsigned CHAN_W = 8;
	localparam int unsigned ACC_W  = PROD_W + CHAN_W;
	localparam int unsigned SHIFT  = 46;

	localparam logic [LVL_W-1:0]  ONE_Q15 = 16'd32768;
	localparam logic [FAC_W-1:0]  ONE_Q31 = 32'h8000_0000;
	localparam logic [CHAN_W-1:0] ALPHA   = 8'hFF;
	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

	typedef enum logic [2:0] {
		SEC_RY = 3'd0,
		SEC_YG = 3'd1,
		SEC_GC = 3'd2,
		SEC_CB = 3'd3,
		SEC_BM = 3'd4,
		SEC_MR = 3'd5
	} sector_t;

	typedef struct packed {
		sector_t            sector;
		logic [LVL_W-1:0]   bright;
		logic [FAC_W-1:0]   kp;
		logic [FAC_W-1:0]   kq;
		logic [FAC_W-1:0]   kt;
	} factor_t;

	typedef struct packed {
		sector_t             sector;
		logic [PROD_W-1:0]   pv;
		logic [PROD_W-1:0]   pp;
		logic [PROD_W-1:0]   pq;
		logic [PROD_W-1:0]   pt;
	} prod_t;

	// x*255 rounded half up at bit SHIFT, saturated to 8 bits
	function automatic logic [CHAN_W-1:0] chan_round(input logic [PROD_W-1:0] p);
		logic [ACC_W-1:0] acc;
		logic [ACC_W-SHIFT-1:0] c;
		acc = {p, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, p};
		acc = acc + (ACC_W'(1) << (SHIFT - 1));
		c = acc[ACC_W-1:SHIFT];
		chan_round = (c > (ACC_W-SHIFT)'(CHAN_MAX)) ? CHAN_MAX : c[CHAN_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/hsv_factor_gen.sv =====
// ----------------------------------------------------------------------------
// hsv_factor_gen
// Stages 1-2: saturation clamp, sector split, scale factors p, q, t in Q1.31.
// ----------------------------------------------------------------------------
module hsv_factor_gen import hsv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [HUE_W-1:0]  hue_turn,
	input  logic [LVL_W-1:0]  sat_level,
	input  logic [LVL_W-1:0]  bright_level,
	output logic              fac_valid,
	output factor_t           fac
);

	logic [HUE_W+2:0]   h6;
	logic [LVL_W-1:0]   sat_cl;
	logic               valid_s1;
	logic [LVL_W-1:0]   sat_s1;
	logic [LVL_W-1:0]   bright_s1;
	logic [FRAC_W-1:0]  frac_s1;
	sector_t            sec_s1;
	logic [LVL_W+FRAC_W-1:0] sf;
	logic [LVL_W+FRAC_W:0]   sg;
	factor_t            fac_d;
	logic               valid_s2;
	factor_t            fac_s2;

	assign h6     = ({3'b000, hue_turn} << 2) + ({3'b000, hue_turn} << 1);
	assign sat_cl = (sat_level > ONE_Q15) ? ONE_Q15 : sat_level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sat_s1    <= sat_cl;
			bright_s1 <= bright_level;
			frac_s1   <= h6[FRAC_W-1:0];
			sec_s1    <= sector_t'(h6[HUE_W+2:FRAC_W]);
		end
	end

	assign sf = (LVL_W+FRAC_W)'(sat_s1) * (LVL_W+FRAC_W)'(frac_s1);
	assign sg = ((LVL_W+FRAC_W+1)'(sat_s1) << FRAC_W) - (LVL_W+FRAC_W+1)'(sf);

	always_comb begin
		fac_d.sector = sec_s1;
		fac_d.bright = bright_s1;
		fac_d.kp     = {ONE_Q15 - sat_s1, {FRAC_W{1'b0}}};
		fac_d.kq     = ONE_Q31 - sf;
		fac_d.kt     = ONE_Q31 - sg[FAC_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fac_s2 <= fac_d;
		end
	end

	assign fac_valid = valid_s2;
	assign fac       = fac_s2;

endmodule

// ===== hw/rtl/hsv_scale_mult.sv =====
// ----------------------------------------------------------------------------
// hsv_scale_mult
// Stage 3: brightness times each scale factor, 16 x 32 products.
// ----------------------------------------------------------------------------
module hsv_scale_mult import hsv_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     fac_valid,
	input  factor_t  fac,
	output logic     prod_valid,
	output prod_t    prod
);

	prod_t prod_d;
	logic  valid_s3;
	prod_t prod_s3;

	always_comb begin
		prod_d.sector = fac.sector;
		prod_d.pv     = PROD_W'(fac.bright) << (FAC_W - 1);
		prod_d.pp     = PROD_W'(fac.bright) * PROD_W'(fac.kp);
		prod_d.pq     = PROD_W'(fac.bright) * PROD_W'(fac.kq);
		prod_d.pt     = PROD_W'(fac.bright) * PROD_W'(fac.kt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= fac_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= prod_d;
		end
	end

	assign prod_valid = valid_s3;
	assign prod       = prod_s3;

endmodule

// ===== hw/rtl/hsv_chan_round.sv =====
// ----------------------------------------------------------------------------
// hsv_chan_round
// Stage 4: scale to 0..255 with rounding and saturation, sector permutation,
// output register.
// ----------------------------------------------------------------------------
module hsv_chan_round import hsv_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               prod_valid,
	input  prod_t              prod,
	output logic               chan_valid,
	output logic [CHAN_W-1:0]  red,
	output logic [CHAN_W-1:0]  green,
	output logic [CHAN_W-1:0]  blue
);

	logic [CHAN_W-1:0] cv, cp, cq, ct;
	logic [CHAN_W-1:0] r_d, g_d, b_d;
	logic              valid_s4;
	logic [CHAN_W-1:0] red_s4, green_s4, blue_s4;

	assign cv = chan_round(prod.pv);
	assign cp = chan_round(prod.pp);
	assign cq = chan_round(prod.pq);
	assign ct = chan_round(prod.pt);

	always_comb begin
		case (prod.sector)
			SEC_RY: begin
				r_d = cv; g_d = ct; b_d = cp;
			end
			SEC_YG: begin
				r_d = cq; g_d = cv; b_d = cp;
			end
			SEC_GC: begin
				r_d = cp; g_d = cv; b_d = ct;
			end
			SEC_CB: begin
				r_d = cp; g_d = cq; b_d = cv;
			end
			SEC_BM: begin
				r_d = ct; g_d = cp; b_d = cv;
			end
			default: begin
				r_d = cv; g_d = cp; b_d = cq;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= prod_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s4   <= r_d;
			green_s4 <= g_d;
			blue_s4  <= b_d;
		end
	end

	assign chan_valid = valid_s4;
	assign red        = red_s4;
	assign green      = green_s4;
	assign blue       = blue_s4;

endmodule

// ===== hw/rtl/hsv_to_rgb_pixel_unit.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel_unit
// HSV to RGB pixel converter. Takes hue as a 16-bit fraction of a turn and
// saturation and brightness in Q1.15 (saturation above 1.0 is clamped) and
// returns 8-bit red, green, blue, rounded half up and saturated, plus an
// opaque ARGB word. Four register stages (sector/clamp, scale factors,
// brightness products, rounding and output register); one pixel per clock
// sustained while out_ready is high. The whole pipeline holds while a
// result waits on out_ready.
// ----------------------------------------------------------------------------
module hsv_to_rgb_pixel_unit import hsv_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [HUE_W-1:0]   hue_turn,
	input  logic [LVL_W-1:0]   sat_level,
	input  logic [LVL_W-1:0]   bright_level,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CHAN_W-1:0]  red_out,
	output logic [CHAN_W-1:0]  green_out,
	output logic [CHAN_W-1:0]  blue_out,
	output logic [4*CHAN_W-1:0] argb_word
);

	logic    en;
	logic    fac_valid;
	factor_t fac;
	logic    prod_valid;
	prod_t   prod;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	hsv_factor_gen u_factor (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (in_valid),
		.hue_turn     (hue_turn),
		.sat_level    (sat_level),
		.bright_level (bright_level),
		.fac_valid    (fac_valid),
		.fac          (fac)
	);

	hsv_scale_mult u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.fac_valid  (fac_valid),
		.fac        (fac),
		.prod_valid (prod_valid),
		.prod       (prod)
	);

	hsv_chan_round u_round (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.prod_valid (prod_valid),
		.prod       (prod),
		.chan_valid (out_valid),
		.red        (red_out),
		.green      (green_out),
		.blue       (blue_out)
	);

	assign argb_word = {ALPHA, red_out, green_out, blue_out};

`ifndef ASSERT_OFF
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	a_prod_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		prod_valid && in_ready |=> out_valid)
		else $error("product stage item lost");

	a_alpha_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> argb_word[4*CHAN_W-1:3*CHAN_W] == ALPHA)
		else $error("alpha not opaque");
`endif

endmodule

// ===== sim/hsv_pixel_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_pixel_checker
// Watches both channels of the HSV to RGB converter. Each input transfer is
// converted to the expected pixel and queued in order. Each output transfer
// is compared field by field with the oldest queued pixel. Reports the error
// count and the number of pixels still outstanding.
// ----------------------------------------------------------------------------
module hsv_pixel_checker import hsv_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [HUE_W-1:0]    hue_turn,
	input  logic [LVL_W-1:0]    sat_level,
	input  logic [LVL_W-1:0]    bright_level,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [CHAN_W-1:0]   red_out,
	input  logic [CHAN_W-1:0]   green_out,
	input  logic [CHAN_W-1:0]   blue_out,
	input  logic [4*CHAN_W-1:0] argb_word,
	output int unsigned         error_count,
	output int unsigned         pending_count
);

	typedef struct packed {
		logic [CHAN_W-1:0]   red;
		logic [CHAN_W-1:0]   green;
		logic [CHAN_W-1:0]   blue;
		logic [4*CHAN_W-1:0] argb;
	} rgb_pixel_t;

	rgb_pixel_t pixel_queue[$];

	// brightness * factor(Q1.31) * 255, rounded half up at bit 46, clipped to 255
	function automatic logic [CHAN_W-1:0] scale_channel(input logic [63:0] bright,
			input logic [63:0] factor);
		logic [63:0] acc;
		acc = bright * factor * 64'd255 + (64'd1 << 45);
		acc = acc >> 46;
		scale_channel = (acc > 64'(CHAN_MAX)) ? CHAN_MAX : acc[CHAN_W-1:0];
	endfunction

	function automatic rgb_pixel_t hsv_to_rgb(input logic [HUE_W-1:0] hue,
			input logic [LVL_W-1:0] sat, input logic [LVL_W-1:0] bright);
		logic [63:0] s, h6, f, kp, kq, kt;
		logic [CHAN_W-1:0] cv, cp, cq, ct;
		sector_t sector;
		rgb_pixel_t px;
		s = (sat > ONE_Q15) ? 64'(ONE_Q15) : 64'(sat);
		h6 = 64'(hue) * 64'd6;
		sector = sector_t'(h6[18:16]);
		f = h6 & 64'hFFFF;
		kp = (64'(ONE_Q15) - s) << 16;
		kq = 64'(ONE_Q31) - s * f;
		kt = 64'(ONE_Q31) - s * (64'd65536 - f);
		cv = scale_channel(64'(bright), 64'(ONE_Q31));
		cp = scale_channel(64'(bright), kp);
		cq = scale_channel(64'(bright), kq);
		ct = scale_channel(64'(bright), kt);
		case (sector)
			SEC_RY: begin px.red = cv; px.green = ct; px.blue = cp; end
			SEC_YG: begin px.red = cq; px.green = cv; px.blue = cp; end
			SEC_GC: begin px.red = cp; px.green = cv; px.blue = ct; end
			SEC_CB: begin px.red = cp; px.green = cq; px.blue = cv; end
			SEC_BM: begin px.red = ct; px.green = cp; px.blue = cv; end
			default: begin px.red = cv; px.green = cp; px.blue = cq; end
		endcase
		px.argb = {ALPHA, px.red, px.green, px.blue};
		hsv_to_rgb = px;
	endfunction

	function automatic int unsigned field_diff(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk) begin
		rgb_pixel_t px;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pixel_queue.size() == 0) begin
					$display("%0t: unexpected output transfer, actual argb %h", $time, argb_word);
					error_count <= error_count + 1;
				end else begin
					px = pixel_queue.pop_front();
					error_count <= error_count
						+ field_diff("red_out", 32'(px.red), 32'(red_out))
						+ field_diff("green_out", 32'(px.green), 32'(green_out))
						+ field_diff("blue_out", 32'(px.blue), 32'(blue_out))
						+ field_diff("argb_word", px.argb, argb_word);
				end
			end
			if (in_valid && in_ready)
				pixel_queue.push_back(hsv_to_rgb(hue_turn, sat_level, bright_level));
			pending_count <= pixel_queue.size();
		end
	end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the HSV to RGB pixel converter. Drives directed corner pixels
// and then random phases with varied idle behavior on both channels,
// including a long output stall and a full drain pause. The checker does the
// prediction and comparison; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top import hsv_pkg::*; ();

	localparam int unsigned IDLE_LIMIT = 5000;
	localparam int unsigned LONG_STALL = 300;
	localparam int unsigned PHASE_LEN  = 275;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [HUE_W-1:0]   hue_turn;
	logic [LVL_W-1:0]   sat_level;
	logic [LVL_W-1:0]   bright_level;
	logic               out_valid;
	logic               out_ready;
	logic [CHAN_W-1:0]  red_out;
	logic [CHAN_W-1:0]  green_out;
	logic [CHAN_W-1:0]  blue_out;
	logic [4*CHAN_W-1:0] argb_word;
	int unsigned        error_count;
	int unsigned        pending_count;

	bit          send_idle;
	bit          recv_idle;
	int unsigned stall_reqs;
	int unsigned quiet_cycles;

	hsv_to_rgb_pixel_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.hue_turn     (hue_turn),
		.sat_level    (sat_level),
		.bright_level (bright_level),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.red_out      (red_out),
		.green_out    (green_out),
		.blue_out     (blue_out),
		.argb_word    (argb_word)
	);

	hsv_pixel_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.hue_turn      (hue_turn),
		.sat_level     (sat_level),
		.bright_level  (bright_level),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.red_out       (red_out),
		.green_out     (green_out),
		.blue_out      (blue_out),
		.argb_word     (argb_word),
		.error_count   (error_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_pixel(input logic [HUE_W-1:0] h, input logic [LVL_W-1:0] s,
			input logic [LVL_W-1:0] v);
		int unsigned gap;
		gap = send_idle ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		hue_turn     <= h;
		sat_level    <= s;
		bright_level <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// mostly in range, sometimes any 16-bit value (possibly above 1.0)
	function automatic logic [LVL_W-1:0] rand_level();
		if ($urandom_range(0, 4) == 0)
			return LVL_W'($urandom);
		return LVL_W'($urandom_range(0, 32768));
	endfunction

	task automatic send_random(input int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			send_pixel(HUE_W'($urandom), rand_level(), rand_level());
	endtask

	// receiver
	initial begin
		int unsigned gap;
		int unsigned stalls_done;
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (stall_reqs != stalls_done) begin
				out_ready <= 1'b0;
				repeat (LONG_STALL) @(posedge clk);
				stalls_done++;
			end else begin
				gap = recv_idle ? $urandom_range(0, 9) : 0;
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// stimulus
	initial begin
		send_idle = 1'b0;
		recv_idle = 1'b0;
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		hue_turn     <= '0;
		sat_level    <= '0;
		bright_level <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners: sector edges, grey, full/zero levels, clamp, half-up rounding
		send_pixel(16'd0,     16'd32768, 16'd32768);
		send_pixel(16'd65535, 16'd32768, 16'd32768);
		send_pixel(16'd10922, 16'd32768, 16'd32768);
		send_pixel(16'd10923, 16'd32768, 16'd32768);
		send_pixel(16'd21845, 16'd32768, 16'd32768);
		send_pixel(16'd21846, 16'd32768, 16'd32768);
		send_pixel(16'd32767, 16'd32768, 16'd32768);
		send_pixel(16'd32768, 16'd32768, 16'd32768);
		send_pixel(16'd43690, 16'd32768, 16'd32768);
		send_pixel(16'd43691, 16'd32768, 16'd32768);
		send_pixel(16'd54613, 16'd32768, 16'd32768);
		send_pixel(16'd54614, 16'd32768, 16'd32768);
		send_pixel(16'd20000, 16'd0,     16'd32768);
		send_pixel(16'd20000, 16'd0,     16'd16384);
		send_pixel(16'd40000, 16'd0,     16'd0);
		send_pixel(16'd5000,  16'd32768, 16'd0);
		send_pixel(16'd5000,  16'd32769, 16'd32768);
		send_pixel(16'd50000, 16'd65535, 16'd20000);
		send_pixel(16'd30000, 16'd16384, 16'd65535);
		send_pixel(16'd60000, 16'd65535, 16'd65535);
		send_pixel(16'd12345, 16'd32767, 16'd32767);
		send_pixel(16'd65535, 16'd0,     16'd65535);

		// back to back
		send_random(PHASE_LEN);

		// long output stall while input keeps offering
		stall_reqs++;
		send_random(PHASE_LEN);

		// drain fully, then both sides idle
		in_valid <= 1'b0;
		while (pending_count != 0) @(posedge clk);
		send_idle = 1'b1;
		recv_idle = 1'b1;
		send_random(PHASE_LEN);

		send_idle = 1'b1;
		recv_idle = 1'b0;
		send_random(PHASE_LEN);

		send_idle = 1'b0;
		recv_idle = 1'b1;
		send_random(PHASE_LEN);

		in_valid <= 1'b0;
		while (pending_count != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
